// ----- rtl/length_prefixed_record_ring_fifo_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the record ring FIFO
// Clocked, reset-qualified property shorthands used by the RTL checks.
// ---------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_RECORD_RING_FIFO_MACROS_SVH
`define LENGTH_PREFIXED_RECORD_RING_FIFO_MACROS_SVH

// Same-cycle implication on i_clk, disabled while i_rst_n is low
`define LPRF_ASSERT_NOW(label, cond, conseq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (conseq)) else $error(msg);

// Next-cycle implication on i_clk, disabled while i_rst_n is low
`define LPRF_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (conseq)) else $error(msg);

`endif

// ----- rtl/lprf_pkg.sv -----
// ---------------------------------------------------------------------------
// lprf_pkg
// Beat types and codes shared by the record ring FIFO.
// ---------------------------------------------------------------------------
package lprf_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;

    // Item kinds
    localparam logic [1:0] KIND_START   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_POP     = 2'd2;
    localparam logic [1:0] KIND_CLEAR   = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NO_SPACE = 2'd1;
    localparam logic [1:0] STAT_EMPTY    = 2'd2;
    localparam logic [1:0] STAT_BAD      = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [LEN_W-1:0]  record_length;
        logic [BYTE_W-1:0] data_byte;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0] data_out;
        logic              last;
        logic [1:0]        status;
        logic              queue_empty;
        logic              queue_full;
    } t_result;

endpackage

// ----- rtl/lprf_ram.sv -----
// ---------------------------------------------------------------------------
// lprf_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module lprf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/length_prefixed_record_ring_fifo.sv -----
// ---------------------------------------------------------------------------
// length_prefixed_record_ring_fifo
// Byte ring FIFO of variable-length records, each a one-byte length header
// followed by its payload. Records are written byte by byte and popped as
// a burst of payload beats.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake                 | beat
//  ---------+-----------+---------------------------+---------------------
//  item     | in        | start high while busy low | i_item   (t_item)
//  result   | out       | o_strobe, one cycle       | o_result (t_result)
//
//  Start, payload, clear and rejected pops: result in the cycle after
//  accept, busy stays low, so one such item per cycle.
//  Successful pop: header read, then one payload beat per cycle from the
//  single RAM read port; busy high until it drops with the last beat.
//  Reset clears pointers and counts; the ring RAM is not cleared, since
//  no entry is read before it is written.
//  Results cannot be stalled by the receiver.
// ---------------------------------------------------------------------------
`include "length_prefixed_record_ring_fifo_macros.svh"

module length_prefixed_record_ring_fifo #(
    parameter int RING_BYTES = 1024,
    parameter int MAX_RECORD = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  lprf_pkg::t_item   i_item,
    output logic              o_strobe,
    output lprf_pkg::t_result o_result
);

    localparam int PTR_W  = $clog2(RING_BYTES);
    localparam int FREE_W = $clog2(RING_BYTES + 1);
    localparam int CMP_W  = ((FREE_W > lprf_pkg::BYTE_W) ? FREE_W : lprf_pkg::BYTE_W) + 1;
    localparam int LEN_W  = lprf_pkg::LEN_W;
    localparam int BYTE_W = lprf_pkg::BYTE_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HDR,
        S_STREAM
    } t_state;

    t_state             r_state,  n_state;
    logic [PTR_W-1:0]   r_wp,     n_wp;
    logic [PTR_W-1:0]   r_rp,     n_rp;
    logic [FREE_W-1:0]  r_free,   n_free;
    logic [LEN_W-1:0]   r_open,   n_open;
    logic [LEN_W-1:0]   r_left,   n_left;
    logic               r_strobe, n_strobe;
    lprf_pkg::t_result  r_res,    n_res;

    logic               accept;
    logic               len_bad;
    logic [CMP_W-1:0]   need;
    logic [CMP_W-1:0]   credit;
    logic [LEN_W-1:0]   hdr_len;
    logic [PTR_W-1:0]   wp_next;
    logic [PTR_W-1:0]   rp_next;

    logic               wr_en;
    logic [BYTE_W-1:0]  wr_data;
    logic               rd_en;
    logic [BYTE_W-1:0]  rd_data;

    lprf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RING_BYTES)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_wp),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rp),
        .o_rd_data (rd_data)
    );

    // Pointer wrap and space arithmetic
    assign accept  = start && (r_state == S_IDLE);
    assign wp_next = (r_wp == PTR_W'(RING_BYTES - 1)) ? '0 : r_wp + PTR_W'(1);
    assign rp_next = (r_rp == PTR_W'(RING_BYTES - 1)) ? '0 : r_rp + PTR_W'(1);
    assign len_bad = (i_item.record_length == '0) ||
                     (i_item.record_length > LEN_W'(MAX_RECORD));
    assign need    = CMP_W'(i_item.record_length) + CMP_W'(1);

    // Clamp a corrupt header to the largest record
    assign hdr_len = ((rd_data == '0) || (rd_data > BYTE_W'(MAX_RECORD))) ?
                     LEN_W'(MAX_RECORD) : rd_data[LEN_W-1:0];
    assign credit  = CMP_W'(r_free) + CMP_W'(hdr_len) + CMP_W'(1);

    // Next-state logic; a RAM write and a read of the same entry never
    // share a cycle, and a read in the cycle after a write sees the new byte
    always_comb begin
        n_state  = r_state;
        n_wp     = r_wp;
        n_rp     = r_rp;
        n_free   = r_free;
        n_open   = r_open;
        n_left   = r_left;
        n_strobe = 1'b0;
        n_res    = r_res;
        wr_en    = 1'b0;
        wr_data  = i_item.data_byte;
        rd_en    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_strobe       = 1'b1;
                    n_res.data_out = '0;
                    n_res.last     = 1'b1;
                    n_res.status   = lprf_pkg::STAT_OK;
                    case (i_item.kind)
                        lprf_pkg::KIND_START: begin
                            if ((r_open != '0) || len_bad) begin
                                n_res.status = lprf_pkg::STAT_BAD;
                            end else if (need >= CMP_W'(r_free)) begin
                                n_res.status = lprf_pkg::STAT_NO_SPACE;
                            end else begin
                                wr_en   = 1'b1;
                                wr_data = BYTE_W'(i_item.record_length);
                                n_wp    = wp_next;
                                n_free  = FREE_W'(CMP_W'(r_free) - need);
                                n_open  = i_item.record_length;
                            end
                        end
                        lprf_pkg::KIND_PAYLOAD: begin
                            if (r_open != '0) begin
                                wr_en  = 1'b1;
                                n_wp   = wp_next;
                                n_open = r_open - LEN_W'(1);
                            end else begin
                                n_res.status = lprf_pkg::STAT_BAD;
                            end
                        end
                        lprf_pkg::KIND_POP: begin
                            if (r_open != '0) begin
                                n_res.status = lprf_pkg::STAT_BAD;
                            end else if (r_free >= FREE_W'(RING_BYTES)) begin
                                n_res.status = lprf_pkg::STAT_EMPTY;
                            end else begin
                                // fetch header, results follow from the stream
                                n_strobe = 1'b0;
                                rd_en    = 1'b1;
                                n_rp     = rp_next;
                                n_state  = S_HDR;
                            end
                        end
                        lprf_pkg::KIND_CLEAR: begin
                            n_wp   = '0;
                            n_rp   = '0;
                            n_free = FREE_W'(RING_BYTES);
                            n_open = '0;
                        end
                        default: begin
                            n_res.status = lprf_pkg::STAT_BAD;
                        end
                    endcase
                    n_res.queue_empty = (n_free == FREE_W'(RING_BYTES));
                    n_res.queue_full  = (n_free == '0);
                end
            end
            S_HDR: begin
                // credit the whole record back and fetch the first byte
                n_left  = hdr_len;
                n_free  = (credit > CMP_W'(RING_BYTES)) ?
                          FREE_W'(RING_BYTES) : FREE_W'(credit);
                rd_en   = 1'b1;
                n_rp    = rp_next;
                n_state = S_STREAM;
            end
            S_STREAM: begin
                n_strobe          = 1'b1;
                n_res.data_out    = rd_data;
                n_res.last        = (r_left == LEN_W'(1));
                n_res.status      = lprf_pkg::STAT_OK;
                n_res.queue_empty = (r_free == FREE_W'(RING_BYTES));
                n_res.queue_full  = (r_free == '0);
                n_left            = r_left - LEN_W'(1);
                if (r_left != LEN_W'(1)) begin
                    rd_en = 1'b1;
                    n_rp  = rp_next;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state, pointers and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wp     <= '0;
            r_rp     <= '0;
            r_free   <= FREE_W'(RING_BYTES);
            r_open   <= '0;
            r_left   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wp     <= n_wp;
            r_rp     <= n_rp;
            r_free   <= n_free;
            r_open   <= n_open;
            r_left   <= n_left;
            r_strobe <= n_strobe;
        end
        r_res <= n_res;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

    // Checks
    `LPRF_ASSERT_NEXT(a_single_beat, accept && (i_item.kind != lprf_pkg::KIND_POP), o_strobe && o_result.last, "non-pop item must give one last beat")
    `LPRF_ASSERT_NEXT(a_burst_cont, o_strobe && !o_result.last, o_strobe, "pop burst broke before its last beat")
    `LPRF_ASSERT_NOW(a_open_reserved, r_open != '0, r_free < FREE_W'(RING_BYTES), "open record without reserved space")
    `LPRF_ASSERT_NOW(a_stream_left, r_state == S_STREAM, r_left != '0, "stream with no bytes left")
    `LPRF_ASSERT_NOW(a_free_bound, r_strobe || !r_strobe, r_free <= FREE_W'(RING_BYTES), "free space above ring size")

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb - record ring FIFO testbench
// Drives start/payload/pop/clear beats in random bursts, keeps a byte-level
// copy of the ring to work out every result beat, and compares the strobed
// results field by field in order of arrival.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    localparam int RING        = 1024;
    localparam int MAX_REC     = 64;
    localparam int STALL_LIMIT = 1000;
    localparam int TAIL_CYCLES = 80;

    typedef struct {
        lprf_pkg::t_item beat;
        bit              pause;
    } t_pending;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    lprf_pkg::t_item   i_item;
    logic              o_strobe;
    lprf_pkg::t_result o_result;

    // Ring contents and bookkeeping as the block should hold them
    bit [7:0] ring_mem [RING];
    int       wr_ptr    = 0;
    int       rd_ptr    = 0;
    int       free_cnt  = RING;
    int       open_left = 0;

    t_pending          items_todo [$];
    lprf_pkg::t_result results_due [$];

    int beats_total = 0;
    int beats_taken = 0;
    int err_cnt     = 0;
    int stall_cnt   = 0;
    int burst_left  = 8;
    int gap_left    = 0;
    bit beat_taken  = 1'b0;

    length_prefixed_record_ring_fifo #(
        .RING_BYTES (RING),
        .MAX_RECORD (MAX_REC)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int ring_bump(input int ptr);
        return (ptr == RING - 1) ? 0 : ptr + 1;
    endfunction

    // Queue one result beat, flags taken from the state after the step
    function automatic void add_result(input logic [7:0] data, input logic last,
                                       input logic [1:0] status);
        lprf_pkg::t_result r;
        r.data_out    = data;
        r.last        = last;
        r.status      = status;
        r.queue_empty = (free_cnt == RING);
        r.queue_full  = (free_cnt == 0);
        results_due.push_back(r);
    endfunction

    // Advance the ring copy by one accepted beat and queue what it causes
    function automatic void apply_item_to_ring(input lprf_pkg::t_item it);
        int len;
        int n;
        len = int'(it.record_length);
        case (it.kind)
            lprf_pkg::KIND_START: begin
                if (open_left != 0 || len == 0 || len > MAX_REC) begin
                    add_result(8'd0, 1'b1, lprf_pkg::STAT_BAD);
                end else if (1 + len >= free_cnt) begin
                    add_result(8'd0, 1'b1, lprf_pkg::STAT_NO_SPACE);
                end else begin
                    ring_mem[wr_ptr] = 8'(len);
                    wr_ptr    = ring_bump(wr_ptr);
                    free_cnt -= 1 + len;
                    open_left = len;
                    add_result(8'd0, 1'b1, lprf_pkg::STAT_OK);
                end
            end
            lprf_pkg::KIND_PAYLOAD: begin
                if (open_left != 0) begin
                    ring_mem[wr_ptr] = it.data_byte;
                    wr_ptr = ring_bump(wr_ptr);
                    open_left--;
                    add_result(8'd0, 1'b1, lprf_pkg::STAT_OK);
                end else begin
                    add_result(8'd0, 1'b1, lprf_pkg::STAT_BAD);
                end
            end
            lprf_pkg::KIND_POP: begin
                if (open_left != 0) begin
                    add_result(8'd0, 1'b1, lprf_pkg::STAT_BAD);
                end else if (free_cnt >= RING) begin
                    add_result(8'd0, 1'b1, lprf_pkg::STAT_EMPTY);
                end else begin
                    n = ring_mem[rd_ptr];
                    rd_ptr = ring_bump(rd_ptr);
                    if (n == 0 || n > MAX_REC) n = MAX_REC;
                    free_cnt += 1 + n;
                    if (free_cnt > RING) free_cnt = RING;
                    for (int i = 0; i < n; i++) begin
                        add_result(ring_mem[rd_ptr], i == n - 1, lprf_pkg::STAT_OK);
                        rd_ptr = ring_bump(rd_ptr);
                    end
                end
            end
            lprf_pkg::KIND_CLEAR: begin
                wr_ptr    = 0;
                rd_ptr    = 0;
                free_cnt  = RING;
                open_left = 0;
                add_result(8'd0, 1'b1, lprf_pkg::STAT_OK);
            end
            default: begin
                add_result(8'd0, 1'b1, lprf_pkg::STAT_BAD);
            end
        endcase
    endfunction

    function automatic void add_beat(input logic [1:0] kind, input logic [6:0] len,
                                     input logic [7:0] data);
        t_pending p;
        p.beat.kind          = kind;
        p.beat.record_length = len;
        p.beat.data_byte     = data;
        p.pause              = 1'b0;
        items_todo.push_back(p);
        beats_total++;
    endfunction

    // Hold the sender until every queued result has come back
    function automatic void add_pause();
        t_pending p;
        p.beat  = '0;
        p.pause = 1'b1;
        items_todo.push_back(p);
    endfunction

    // Well-formed record: start beat, then one payload beat per byte
    function automatic int add_record(input int len);
        add_beat(lprf_pkg::KIND_START, 7'(len), 8'($urandom));
        for (int i = 0; i < len; i++)
            add_beat(lprf_pkg::KIND_PAYLOAD, 7'($urandom), 8'($urandom));
        return len + 1;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    // Drive the next beat at the falling edge; hold it until taken
    always @(negedge i_clk) begin
        t_pending nxt;
        if (i_rst_n && (!start || beat_taken)) begin
            if (gap_left > 0) begin
                start <= 1'b0;
                gap_left--;
            end else if (items_todo.size() == 0) begin
                start <= 1'b0;
            end else if (items_todo[0].pause) begin
                start <= 1'b0;
                if (results_due.size() == 0) void'(items_todo.pop_front());
            end else begin
                nxt = items_todo.pop_front();
                start  <= 1'b1;
                i_item <= nxt.beat;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // Check result beats against the oldest prediction, then predict new ones
    always @(posedge i_clk) begin
        lprf_pkg::t_result want;
        if (i_rst_n) begin
            beat_taken = start && !busy;
            if (o_strobe) begin
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, got %h",
                             $time, o_result);
                    err_cnt++;
                end else begin
                    want = results_due.pop_front();
                    check_field("data_out", want.data_out, o_result.data_out);
                    check_field("last", 8'(want.last), 8'(o_result.last));
                    check_field("status", 8'(want.status), 8'(o_result.status));
                    check_field("queue_empty", 8'(want.queue_empty),
                                8'(o_result.queue_empty));
                    check_field("queue_full", 8'(want.queue_full),
                                8'(o_result.queue_full));
                end
            end
            if (beat_taken) begin
                apply_item_to_ring(i_item);
                beats_taken++;
            end
            stall_cnt = (beat_taken || o_strobe) ? 0 : stall_cnt + 1;
        end
    end

    initial begin
        int count;
        int r;
        int len;
        int cut;

        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;

        // Directed: rejects of start, payload and pop beats, field extremes, abandon by clear
        add_beat(lprf_pkg::KIND_POP,     7'd0,   8'h00);
        add_beat(lprf_pkg::KIND_PAYLOAD, 7'd127, 8'h3C);
        add_beat(lprf_pkg::KIND_START,   7'd0,   8'hFF);
        add_beat(lprf_pkg::KIND_START,   7'd65,  8'h00);
        add_beat(lprf_pkg::KIND_START,   7'd127, 8'hFF);
        add_beat(lprf_pkg::KIND_START,   7'd2,   8'h00);
        add_beat(lprf_pkg::KIND_POP,     7'd127, 8'hFF);
        add_beat(lprf_pkg::KIND_START,   7'd1,   8'h00);
        add_beat(lprf_pkg::KIND_PAYLOAD, 7'd127, 8'h00);
        add_beat(lprf_pkg::KIND_PAYLOAD, 7'd0,   8'hFF);
        add_beat(lprf_pkg::KIND_PAYLOAD, 7'd5,   8'h11);
        add_beat(lprf_pkg::KIND_POP,     7'd0,   8'h00);
        add_beat(lprf_pkg::KIND_POP,     7'd0,   8'h00);
        add_beat(lprf_pkg::KIND_START,   7'd3,   8'h00);
        add_beat(lprf_pkg::KIND_PAYLOAD, 7'd0,   8'hA5);
        add_beat(lprf_pkg::KIND_CLEAR,   7'd127, 8'hFF);
        add_beat(lprf_pkg::KIND_PAYLOAD, 7'd0,   8'h5A);
        add_beat(lprf_pkg::KIND_POP,     7'd0,   8'h00);
        add_beat(lprf_pkg::KIND_START,   7'd1,   8'h00);
        add_beat(lprf_pkg::KIND_PAYLOAD, 7'd0,   8'h7E);
        add_beat(lprf_pkg::KIND_POP,     7'd0,   8'h00);
        add_beat(lprf_pkg::KIND_CLEAR,   7'd0,   8'h00);
        add_pause();

        // Fill to the space limit, drain, then write across the ring end
        add_beat(lprf_pkg::KIND_CLEAR, 7'd0, 8'h00);
        for (int i = 0; i < 15; i++) void'(add_record(MAX_REC));
        add_beat(lprf_pkg::KIND_START, 7'd48, 8'h00);
        void'(add_record(47));
        add_beat(lprf_pkg::KIND_START, 7'd1, 8'h00);
        add_beat(lprf_pkg::KIND_PAYLOAD, 7'd0, 8'hC3);
        for (int i = 0; i < 17; i++)
            add_beat(lprf_pkg::KIND_POP, 7'($urandom), 8'($urandom));
        for (int i = 0; i < 3; i++) void'(add_record($urandom_range(1, MAX_REC)));
        for (int i = 0; i < 3; i++) add_beat(lprf_pkg::KIND_POP, 7'd0, 8'h00);
        add_pause();

        // Random: mostly whole records and pops, some broken records and noise
        count = 0;
        while (count < 130) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_REC)
                                                  : $urandom_range(1, 8);
                count += add_record(len);
            end else if (r < 75) begin
                add_beat(lprf_pkg::KIND_POP, 7'($urandom), 8'($urandom));
                count++;
            end else if (r < 80) begin
                len = $urandom_range(2, 8);
                cut = $urandom_range(0, len - 1);
                add_beat(lprf_pkg::KIND_START, 7'(len), 8'($urandom));
                for (int i = 0; i < cut; i++)
                    add_beat(lprf_pkg::KIND_PAYLOAD, 7'($urandom), 8'($urandom));
                add_beat(($urandom_range(0, 1) == 0) ? lprf_pkg::KIND_POP
                                                     : lprf_pkg::KIND_START,
                         7'($urandom_range(1, 4)), 8'($urandom));
                count += cut + 2;
            end else if (r < 84) begin
                add_beat(lprf_pkg::KIND_CLEAR, 7'($urandom), 8'($urandom));
                count++;
            end else if (r < 92) begin
                add_beat(2'($urandom), 7'($urandom), 8'($urandom));
                count++;
            end else if (r < 97) begin
                add_beat(lprf_pkg::KIND_START, 7'($urandom_range(0, 127)), 8'($urandom));
                count++;
            end else begin
                add_pause();
            end
        end

        // Reset once, release on a falling edge
        repeat (12) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        while (!(beats_taken == beats_total && results_due.size() == 0)
               && stall_cnt < STALL_LIMIT)
            @(negedge i_clk);

        if (stall_cnt >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, results_due.size());
            err_cnt++;
        end else begin
            repeat (TAIL_CYCLES) @(negedge i_clk);
        end

        if (err_cnt == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
